// ===== design/windowed_sum_flow_detector_macros.svh =====
// Assertion macros used by the checker file of the windowed-sum flow detector.
// No dependencies; included by bare file name.
`ifndef WINDOWED_SUM_FLOW_DETECTOR_MACROS_SVH
`define WINDOWED_SUM_FLOW_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wsfd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wsfd check failed");

`endif

// ===== design/wsfd_pkg.sv =====
// Constants and register indexes of the windowed-sum flow detector.
// No dependencies; used by scoped names from the top level, the checker and the bench.
package wsfd_pkg;

	localparam int WINDOW_LEN = 15;
	localparam int ADDR_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int ENTRY_MAX  = 255;
	localparam int SUM_MAX    = WINDOW_LEN * ENTRY_MAX;
	localparam int SUM_W      = $clog2(SUM_MAX + 1);
	localparam int OUT_SUM_W  = 12;
	localparam int SUM_X_W    = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;
	localparam int OUT_SUM_MAX = (1 << OUT_SUM_W) - 1;

	localparam logic [6:0]  ENTRY_SCALE = 7'd120;
	localparam logic [15:0] THRESHOLD_RESET = 16'd500;
	localparam logic [7:0]  FILL_RESET = 8'd66;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE     = 2'd1;

	localparam logic [1:0] MODE_AUTO_START = 2'd0;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

endpackage

// ===== design/windowed_sum_flow_detector.sv =====
// Windowed-sum flow detector: throughput one beat per clock while the output is not stalled; an accepted
// input beat passes stage 1 and the output register (read window memory, then update sum and write back).
// The window lives in a one-read/one-write synchronous RAM; a refill clears per-entry valid
// flops, so an entry not yet rewritten reads as the latched fill value. No clearing pass.
// arst_n clears control state: window reads as fill value 66, sum 15*66, pointer 0, rearm set,
// threshold 500. Depends on wsfd_pkg.
module windowed_sum_flow_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [wsfd_pkg::IN_DATA_W-1:0]      s_tdata,  // sample[15:0], hold[16], mode[18:17]
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wsfd_pkg::OUT_DATA_W-1:0]     m_tdata,  // window_sum[11:0], flow_present[12]
	// configuration writes
	input  logic                                cfg_we,
	input  logic [wsfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wsfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = wsfd_pkg::ADDR_W;
	localparam int SW = wsfd_pkg::SUM_W;
	localparam int XW = wsfd_pkg::SUM_X_W;
	localparam int OW = wsfd_pkg::OUT_SUM_W;

	// ---------------- configuration registers ----------------
	logic [15:0] threshold_q;
	logic [7:0]  fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= wsfd_pkg::THRESHOLD_RESET;
			fill_q      <= wsfd_pkg::FILL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wsfd_pkg::REG_FLOW_THRESHOLD: threshold_q <= cfg_data;
				wsfd_pkg::REG_FILL_VALUE:     fill_q      <= cfg_data[7:0];
				default: ;  // unknown index: ignored
			endcase
		end
	end

	// ---------------- input decode (stage 0) ----------------
	logic signed [15:0] sample;
	logic               hold;
	logic [1:0]         mode;
	assign sample = s_tdata[15:0];
	assign hold   = s_tdata[16];
	assign mode   = s_tdata[18:17];

	logic accept;
	logic valid_s1;
	logic s1_go;

	assign s1_go    = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || s1_go;
	assign accept   = s_tvalid && s_tready;

	// Control decisions need only flop state and the input beat, so they resolve at accept.
	logic          rearm_q;
	logic [AW-1:0] ptr_q;
	logic          do_refill;
	logic          do_write;
	logic [AW-1:0] ptr_inc;

	assign do_refill = rearm_q && (mode == wsfd_pkg::MODE_AUTO_START);
	assign do_write  = !do_refill && !hold;
	assign ptr_inc   = (ptr_q == AW'(wsfd_pkg::WINDOW_LEN - 1)) ? '0 : ptr_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rearm_q <= 1'b1;
			ptr_q   <= '0;
		end else if (accept) begin
			rearm_q <= do_refill ? 1'b0 : (rearm_q | mode[1]);
			if (do_refill)
				ptr_q <= '0;
			else if (do_write)
				ptr_q <= ptr_inc;
		end
	end

	// Scaled magnitude: (120*|sample|) >> 12, saturated to 255.
	logic [16:0] mag;
	logic [23:0] prod;
	logic [7:0]  entry_new;

	assign mag       = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
	assign prod      = 24'(mag) * 24'(wsfd_pkg::ENTRY_SCALE);
	assign entry_new = (|prod[23:20]) ? 8'(wsfd_pkg::ENTRY_MAX) : prod[19:12];

	// ---------------- window memory ----------------
	logic [7:0] win_mem [wsfd_pkg::WINDOW_LEN];
	logic [7:0] rd_q;
	logic       win_vld_q [wsfd_pkg::WINDOW_LEN];
	logic [7:0] refill_val_q;

	// stage 1 pipeline registers
	logic          refill_s1;
	logic          write_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    entry_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_data_s1;

	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= win_mem[ptr_q];
		if (s1_go && write_s1)
			win_mem[addr_s1] <= entry_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of stage 1. Forward when the read just issued hits the entry being written.
	always_ff @(posedge clk) begin
		if (accept) begin
			refill_s1   <= do_refill;
			write_s1    <= do_write;
			addr_s1     <= ptr_q;
			entry_s1    <= entry_new;
			fwd_s1      <= s1_go && write_s1 && (addr_s1 == ptr_q);
			fwd_data_s1 <= entry_s1;
		end
	end

	// ---------------- stage 1: read-modify-write of the sum ----------------
	logic [7:0]    old_entry;
	logic [SW-1:0] sum_q;
	logic [SW-1:0] sum_next;
	logic [SW-1:0] sum_refill;

	assign old_entry  = fwd_s1 ? fwd_data_s1 :
	                    (win_vld_q[addr_s1] ? rd_q : refill_val_q);
	assign sum_refill = SW'(wsfd_pkg::WINDOW_LEN * fill_q);
	assign sum_next   = refill_s1 ? sum_refill :
	                    write_s1  ? (sum_q - SW'(old_entry) + SW'(entry_s1)) : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= SW'(wsfd_pkg::WINDOW_LEN * wsfd_pkg::FILL_RESET);
			refill_val_q <= wsfd_pkg::FILL_RESET;
			for (int i = 0; i < wsfd_pkg::WINDOW_LEN; i++)
				win_vld_q[i] <= 1'b0;
		end else if (s1_go) begin
			sum_q <= sum_next;
			if (refill_s1) begin
				refill_val_q <= fill_q;
				for (int i = 0; i < wsfd_pkg::WINDOW_LEN; i++)
					win_vld_q[i] <= 1'b0;
			end else if (write_s1) begin
				win_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	// ---------------- output register ----------------
	logic [XW-1:0] sum_ext;
	logic [OW-1:0] sum_sat;
	logic          flow_now;
	logic [OW-1:0] out_sum_q;
	logic          out_flow_q;

	assign sum_ext  = XW'(sum_next);
	assign sum_sat  = (sum_ext > XW'(wsfd_pkg::OUT_SUM_MAX)) ? OW'(wsfd_pkg::OUT_SUM_MAX)
	                                                         : sum_ext[OW-1:0];
	assign flow_now = (16'(sum_next) >= threshold_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_go) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_sum_q  <= sum_sat;
			out_flow_q <= flow_now;
		end
	end

	assign m_tdata = {3'b000, out_flow_q, out_sum_q};

endmodule

// ===== design/wsfd_checker.sv =====
// Port-level checks for the windowed-sum flow detector, bound to the top level.
// Depends on wsfd_pkg and windowed_sum_flow_detector_macros.svh.
`include "windowed_sum_flow_detector_macros.svh"

module wsfd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [wsfd_pkg::IN_DATA_W-1:0]    s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [wsfd_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic                              cfg_we,
	input logic [wsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [wsfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// stalled result beat holds
	`WSFD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// the sum never exceeds a full window of saturated entries
	`WSFD_ASSERT_NOW(a_sum_bound, clk, arst_n, m_tvalid, m_tdata[11:0] <= 12'(wsfd_pkg::SUM_MAX))

	// a result appearing on an idle output came from a beat taken through stage 1 and the output register
	`WSFD_ASSERT_NOW(a_latency, clk, arst_n, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind windowed_sum_flow_detector wsfd_checker u_wsfd_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking bench for windowed_sum_flow_detector: directed tests, then random traffic.
// Keeps its own model of the window, sum and rearm flag and scores every output beat.
// Depends on wsfd_pkg and the detector RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN         = wsfd_pkg::WINDOW_LEN;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int DRAIN_TAIL  = 8;      // idle tail after the last result, past the pipeline latency
	localparam int PRINT_CAP   = 40;

	// register indexes the block does not decode; writes to them must be dropped
	localparam logic [wsfd_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [wsfd_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum logic [1:0] {
		MODE_AUTO        = wsfd_pkg::MODE_AUTO_START,
		MODE_OTHER       = 2'd1,
		MODE_STEADY_AUTO = 2'd2,
		MODE_MANUAL      = 2'd3
	} flow_mode_e;

	typedef struct packed {
		logic [11:0] window_sum;
		logic        flow_present;
	} flow_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [wsfd_pkg::IN_DATA_W-1:0]      s_tdata = '0;  // sample[15:0], hold[16], mode[18:17]
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [wsfd_pkg::OUT_DATA_W-1:0]     m_tdata;       // window_sum[11:0], flow_present[12]
	logic                                cfg_we = 1'b0;
	logic [wsfd_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [wsfd_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

	windowed_sum_flow_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- window model
	logic [7:0]   window_copy [WIN];
	int           window_total;
	int           write_slot;
	bit           rearm_armed;
	int           threshold_reg;
	logic [7:0]   fill_reg;
	flow_result_t pending_results [$];

	int mismatch_count;
	int beats_scored;

	// traffic shaping knobs, changed between phases
	bit sender_no_gaps;
	bit sink_no_stalls;
	int burst_left;

	function automatic logic [7:0] scaled_entry(input logic signed [15:0] sample);
		logic [16:0] mag;
		logic [23:0] prod;
		mag  = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
		prod = (24'(mag) * 24'd120) >> 12;
		return (prod > 24'd255) ? 8'hFF : prod[7:0];
	endfunction

	task automatic refill_window_copy();
		for (int i = 0; i < WIN; i++)
			window_copy[i] = fill_reg;
		window_total = WIN * fill_reg;
		write_slot   = 0;
	endtask

	// one accepted beat: rearm first, then a refill, a window update, or nothing for a held beat
	task automatic advance_window(input logic signed [15:0] sample, input logic hold,
		input flow_mode_e mode);
		logic [7:0]   entry;
		flow_result_t res;
		if (mode == MODE_STEADY_AUTO || mode == MODE_MANUAL)
			rearm_armed = 1'b1;
		if (rearm_armed && mode == MODE_AUTO) begin
			refill_window_copy();   // hold has no say here
			rearm_armed = 1'b0;
		end else if (!hold) begin
			entry = scaled_entry(sample);
			window_total = window_total - window_copy[write_slot] + entry;
			window_copy[write_slot] = entry;
			write_slot = (write_slot == WIN - 1) ? 0 : write_slot + 1;
		end
		res.window_sum = (window_total > wsfd_pkg::OUT_SUM_MAX) ?
			12'(wsfd_pkg::OUT_SUM_MAX) : 12'(window_total);
		res.flow_present = (window_total >= threshold_reg);
		pending_results.push_back(res);
	endtask

	// ---------------------------------------------------------------- scoring
	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH beat %0d %s: got %0d, expected %0d",
				beats_scored, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : result_check
		flow_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", int'(m_tdata), -1);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[11:0] !== want.window_sum)
					report_mismatch("window_sum", int'(m_tdata[11:0]), int'(want.window_sum));
				if (m_tdata[12] !== want.flow_present)
					report_mismatch("flow_present", int'(m_tdata[12]), int'(want.flow_present));
			end
			beats_scored++;
		end
	end

	// ---------------------------------------------------------------- result backpressure
	// A rotating 32-bit ready pattern, reloaded now and then with a denser or sparser mix.
	logic [31:0] stall_pattern = 32'hFFFF_FFFF;
	int          stall_age;

	always @(posedge clk) begin
		if (sink_no_stalls) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= stall_pattern[0];
			if (stall_age == 0)
				stall_pattern <= ($urandom_range(0, 1) != 0) ? ($urandom() | $urandom()) :
					(($urandom() & $urandom()) | 32'h1);
			else
				stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
			stall_age <= (stall_age >= 45) ? 0 : stall_age + 1;
		end
	end

	// ---------------------------------------------------------------- watchdog
	int cycle_count;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus helpers
	// Called right after a rising edge; returns at the edge where the beat was taken.
	task automatic send_item(input logic signed [15:0] sample, input logic hold,
		input flow_mode_e mode);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = sender_no_gaps ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tdata  <= {{(wsfd_pkg::IN_DATA_W - 19){1'b0}}, mode, hold, sample};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_window(sample, hold, mode);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// only while drained; cfg_we is left high, the caller lowers it after its last write
	task automatic write_register(input logic [wsfd_pkg::CFG_IDX_W-1:0] idx,
		input logic [wsfd_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == wsfd_pkg::REG_FLOW_THRESHOLD)
			threshold_reg = int'(data);
		else if (idx == wsfd_pkg::REG_FILL_VALUE)
			fill_reg = data[7:0];
	endtask

	task automatic configure(input logic [15:0] thr, input logic [7:0] fill);
		drain_results();
		write_register(wsfd_pkg::REG_FLOW_THRESHOLD, thr);
		// junk in the upper byte must be masked off
		write_register(wsfd_pkg::REG_FILL_VALUE, {8'($urandom()), fill});
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests
	// after reset: window full of 66, sum 990, threshold 500 -> flow present
	task automatic test_reset_defaults();
		send_item(16'sd0, 1'b1, MODE_OTHER);
	endtask

	// rearm is set out of reset, so the first auto-start beat refills and ignores hold
	task automatic test_mode_rearm();
		send_item(16'sh7FFF, 1'b1, MODE_AUTO);
		send_item(-16'sd32768, 1'b0, MODE_AUTO);   // flag cleared: plain update
		send_item(16'sd4096, 1'b1, MODE_STEADY_AUTO);
		send_item(16'sd4096, 1'b1, MODE_AUTO);     // refill with hold high
		send_item(16'sd1000, 1'b0, MODE_MANUAL);   // arms and still updates
		send_item(16'sd2000, 1'b1, MODE_OTHER);    // held: no change
		send_item(16'sd3000, 1'b0, MODE_AUTO);
	endtask

	// truncation at zero and one, the saturation knee, both extremes, most-negative input
	task automatic test_sample_scaling();
		send_item(16'sd34, 1'b0, MODE_OTHER);
		send_item(16'sd35, 1'b0, MODE_OTHER);
		send_item(-16'sd35, 1'b0, MODE_OTHER);
		send_item(16'sd8738, 1'b0, MODE_OTHER);
		send_item(-16'sd8739, 1'b0, MODE_OTHER);
		send_item(16'sh7FFF, 1'b0, MODE_OTHER);
		send_item(-16'sd32768, 1'b0, MODE_OTHER);
		send_item(16'sh5555, 1'b0, MODE_OTHER);
		send_item(16'shAAAA, 1'b0, MODE_OTHER);
	endtask

	// sum equal to threshold counts as flow; one above does not; then the extremes
	task automatic test_threshold_edges();
		configure(16'd990, 8'd66);
		send_item(16'sd0, 1'b1, MODE_MANUAL);
		send_item(16'sd0, 1'b0, MODE_AUTO);
		drain_results();
		write_register(wsfd_pkg::REG_FLOW_THRESHOLD, 16'd991);
		cfg_we <= 1'b0;
		send_item(16'sd0, 1'b1, MODE_OTHER);
		configure(16'd0, 8'd66);
		send_item(16'sd0, 1'b1, MODE_OTHER);
		configure(16'hFFFF, 8'd66);
		send_item(16'sd0, 1'b1, MODE_OTHER);
	endtask

	// new fill only lands at the next refill
	task automatic test_fill_value_change();
		configure(16'd3825, 8'd255);
		send_item(16'sd0, 1'b1, MODE_OTHER);
		send_item(16'sd0, 1'b1, MODE_STEADY_AUTO);
		send_item(16'sd0, 1'b1, MODE_AUTO);        // full-scale window: 3825
		configure(16'd1, 8'd0);
		send_item(16'sd0, 1'b0, MODE_MANUAL);
		send_item(16'sd0, 1'b0, MODE_AUTO);        // empty window
	endtask

	task automatic test_unknown_register();
		drain_results();
		write_register(REG_SPARE_2, 16'($urandom()));
		write_register(REG_SPARE_3, 16'($urandom()));
		cfg_we <= 1'b0;
		send_item(16'sd0, 1'b1, MODE_OTHER);
	endtask

	// Mostly window updates with random magnitudes, sprinkled with rearm/refill
	// sequences and held beats; each phase runs under its own settings and pacing.
	task automatic test_random_traffic();
		int         pick;
		int         mag;
		logic [15:0] thr;
		logic signed [15:0] sample;
		flow_mode_e mode;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: configure(16'($urandom_range(500, 3800)), 8'($urandom()));
				1: configure(16'd0, 8'd255);
				2: configure(16'hFFFF, 8'd0);
				default: begin
					thr = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
						16'($urandom_range(0, 3825));
					configure(thr, 8'($urandom()));
				end
			endcase
			sender_no_gaps = (phase % 3 == 1);
			sink_no_stalls = (phase % 3 == 2);
			for (int n = 0; n < 105; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 68)
					mode = MODE_OTHER;
				else if (pick < 80)
					mode = MODE_AUTO;
				else if (pick < 90)
					mode = MODE_STEADY_AUTO;
				else
					mode = MODE_MANUAL;
				case ($urandom_range(0, 3))
					0: mag = -1;                          // raw 16-bit word
					1: mag = $urandom_range(0, 8739);     // spans the whole entry range
					2: mag = $urandom_range(0, 300);
					default: mag = $urandom_range(8600, 8900);
				endcase
				if (mag < 0)
					sample = 16'($urandom());
				else
					sample = ($urandom_range(0, 1) != 0) ? -16'(mag) : 16'(mag);
				send_item(sample, ($urandom_range(0, 4) == 0), mode);
			end
		end
		sender_no_gaps = 1'b0;
		sink_no_stalls = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		threshold_reg = int'(wsfd_pkg::THRESHOLD_RESET);
		fill_reg      = wsfd_pkg::FILL_RESET;
		refill_window_copy();
		rearm_armed   = 1'b1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_mode_rearm();
		test_sample_scaling();
		test_threshold_edges();
		test_fill_value_change();
		test_unknown_register();
		test_random_traffic();

		drain_results();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
